[design/rlpe_pkg.sv]
// Package for the RGB LED pulse encoder: widths, register indexes and the
// constant-divide helpers used by the datapath.
// No dependencies.
package rlpe_pkg;

   localparam int BITS_PER_PIXEL = 24;
   localparam int CNT_W          = $clog2(BITS_PER_PIXEL);
   localparam int COLOR_W        = 8;
   localparam int PROD_W         = 2 * COLOR_W;
   localparam int DUTY_W         = 16;
   localparam int REPEAT_W       = 6;
   localparam int RESET_SLOTS    = 50;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   localparam logic [DUTY_W-1:0]  PERIOD_RESET     = DUTY_W'(90);
   localparam logic [COLOR_W-1:0] BRIGHTNESS_RESET = COLOR_W'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMER_PERIOD = 2'd0,
      CSR_BRIGHTNESS   = 2'd1
   } csr_index_type;

   // x / 3 for a 17-bit x: multiply by ceil(2^18/3) and drop 18 bits.
   function automatic logic [DUTY_W-1:0] div3(input logic [DUTY_W:0] x);
      logic [2*DUTY_W+1:0] p;
      p = (2*DUTY_W+2)'(x) * (2*DUTY_W+2)'(87382);
      return p[DUTY_W+17:18];
   endfunction

   // x / 255 for a product of two bytes.
   function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = (PROD_W+1)'(x) + (PROD_W+1)'(x[PROD_W-1:COLOR_W]) + (PROD_W+1)'(1);
      return s[PROD_W-1:COLOR_W];
   endfunction

endpackage

[design/rgb_led_pulse_encoder_top.sv]
// Top level of the RGB LED pulse encoder: brightness scaling, bit
// serializer and PWM duty word generation.
// Depends on rlpe_pkg.
//
// Usage:
//   Pixel channel: drive req_* and raise start; a pixel is taken at a clock
//   edge where start is high and busy is low.
//   Result channel: one duty word per cycle, marked by rsp_valid for one
//   cycle. The receiver cannot stall, so results are never held back.
//   Each pixel gives 24 beats, MSB of the first colour first; a pixel with
//   last_pixel set gives a 25th beat with duty 0 and repeat count 50 (the
//   latch gap). rsp_run_end marks the final beat of each pixel.
//   Path: with the serializer idle, an accepted pixel passes the product
//   register and then the shift register before its first beat is on the
//   result ports.
//   Throughput: the serializer emits one bit per cycle. A pixel is
//   buffered while the previous one drains, so beats run back to back.
//   Config port: csr_ready is always high; index 0 is timer_period,
//   index 1 is brightness, other indexes are ignored. Write only while idle.
//   Reset: synchronous; period 90, brightness 255, pipeline empty.
module rgb_led_pulse_encoder_top
   import rlpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COLOR_W-1:0]    req_first_color,
   input  logic [COLOR_W-1:0]    req_second_color,
   input  logic [COLOR_W-1:0]    req_third_color,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   output logic [DUTY_W-1:0]     rsp_duty_value,
   output logic [REPEAT_W-1:0]   rsp_repeat_count,
   output logic                  rsp_run_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_PIXEL - 1);

   logic [DUTY_W-1:0]          period_ff, period_in;
   logic [COLOR_W-1:0]         bright_ff, bright_in;
   logic [DUTY_W-1:0]          duty_one_ff, duty_zero_ff;

   logic                       hold_valid_ff, hold_valid_in;
   logic                       hold_last_ff;
   logic [PROD_W-1:0]          prod0_ff, prod1_ff, prod2_ff;

   logic                       active_ff, active_in;
   logic                       gap_ff, gap_in;
   logic                       last_ff, last_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [BITS_PER_PIXEL-1:0]  shift_ff, shift_in;

   logic accept, done_beat, free, load;

   assign csr_ready = 1'b1;

   always_comb begin
      period_in = period_ff;
      bright_in = bright_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMER_PERIOD: period_in = csr_data;
            CSR_BRIGHTNESS:   bright_in = csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Serializer control
   assign done_beat = active_ff && (gap_ff || (cnt_ff == LAST_BIT && !last_ff));
   assign free      = !active_ff || done_beat;
   assign load      = free && hold_valid_ff;
   assign busy      = hold_valid_ff && !free;
   assign accept    = start && !busy;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end

      active_in = active_ff;
      gap_in    = gap_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      if (load) begin
         active_in = 1'b1;
         gap_in    = 1'b0;
         last_in   = hold_last_ff;
         cnt_in    = '0;
         shift_in  = {div255(prod0_ff), div255(prod1_ff), div255(prod2_ff)};
      end else if (free) begin
         active_in = 1'b0;
      end else if (cnt_ff == LAST_BIT) begin
         // last data bit of a final pixel: emit the latch gap next
         gap_in = 1'b1;
      end else begin
         cnt_in   = cnt_ff + CNT_W'(1);
         shift_in = {shift_ff[BITS_PER_PIXEL-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PERIOD_RESET;
         bright_ff     <= BRIGHTNESS_RESET;
         duty_one_ff   <= div3({PERIOD_RESET, 1'b0});
         duty_zero_ff  <= div3({1'b0, PERIOD_RESET});
         hold_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         gap_ff        <= 1'b0;
      end else begin
         period_ff     <= period_in;
         bright_ff     <= bright_in;
         duty_one_ff   <= div3({period_ff, 1'b0});
         duty_zero_ff  <= div3({1'b0, period_ff});
         hold_valid_ff <= hold_valid_in;
         active_ff     <= active_in;
         gap_ff        <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod0_ff     <= PROD_W'(req_first_color) * PROD_W'(bright_ff);
         prod1_ff     <= PROD_W'(req_second_color) * PROD_W'(bright_ff);
         prod2_ff     <= PROD_W'(req_third_color) * PROD_W'(bright_ff);
         hold_last_ff <= req_last_pixel;
      end
      last_ff  <= last_in;
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
   end

   always_comb begin
      rsp_valid = active_ff;
      if (gap_ff) begin
         rsp_duty_value   = '0;
         rsp_repeat_count = REPEAT_W'(RESET_SLOTS);
         rsp_run_end      = 1'b1;
      end else begin
         rsp_duty_value   = shift_ff[BITS_PER_PIXEL-1] ? duty_one_ff : duty_zero_ff;
         rsp_repeat_count = REPEAT_W'(1);
         rsp_run_end      = (cnt_ff == LAST_BIT) && !last_ff;
      end
   end

endmodule

[verif/rgb_led_pulse_encoder_top_tb.sv]
// Self-checking testbench for rgb_led_pulse_encoder_top: drives pixels and
// register writes, predicts every duty word and compares it at the output.
// Depends on rlpe_pkg and the design sources only.
module rgb_led_pulse_encoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlpe_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 6;
   localparam int REPORT_LIMIT    = 10;
   localparam int PHASE_PIXELS    = 35;
   localparam int NUM_PHASES      = 6;

   // indexes past the register list; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 2'd3;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty;
      logic [REPEAT_W-1:0] reps;
      logic                run_end;
   } duty_beat_type;

   class duty_word_checker_type;
      logic [DUTY_W-1:0]  period;
      logic [COLOR_W-1:0] bright;
      duty_beat_type      due_words[$];
      int                 failures;
      int                 pixels_seen;
      int                 frames_seen;
      int                 beats_checked;

      function new();
         period        = PERIOD_RESET;
         bright        = BRIGHTNESS_RESET;
         failures      = 0;
         pixels_seen   = 0;
         frames_seen   = 0;
         beats_checked = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TIMER_PERIOD: period = data;
            CSR_BRIGHTNESS:   bright = data[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [COLOR_W-1:0] scale(input logic [COLOR_W-1:0] c);
         int unsigned prod;
         prod = 32'(c) * 32'(bright);
         return COLOR_W'(prod / 255);
      endfunction

      function void take_pixel(input logic [COLOR_W-1:0] c0, c1, c2,
                               input logic last);
         logic [BITS_PER_PIXEL-1:0] word;
         int unsigned one_duty;
         int unsigned zero_duty;
         duty_beat_type b;
         word      = {scale(c0), scale(c1), scale(c2)};
         one_duty  = (32'(period) * 2) / 3;
         zero_duty = 32'(period) / 3;
         for (int i = BITS_PER_PIXEL - 1; i >= 0; i--) begin
            b.duty    = word[i] ? DUTY_W'(one_duty) : DUTY_W'(zero_duty);
            b.reps    = REPEAT_W'(1);
            b.run_end = !last && (i == 0);
            due_words.push_back(b);
         end
         if (last) begin
            b.duty    = '0;
            b.reps    = REPEAT_W'(RESET_SLOTS);
            b.run_end = 1'b1;
            due_words.push_back(b);
            frames_seen++;
         end
         pixels_seen++;
      endfunction

      function void report(input string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
      endfunction

      function void check_beat(input logic [DUTY_W-1:0] duty,
                               input logic [REPEAT_W-1:0] reps,
                               input logic run_end);
         duty_beat_type want;
         if (due_words.size() == 0) begin
            report($sformatf("unexpected beat duty %0d reps %0d end %0b",
                             duty, reps, run_end));
            return;
         end
         want = due_words.pop_front();
         if (want.duty !== duty || want.reps !== reps || want.run_end !== run_end)
            report($sformatf("beat %0d: expected duty %0d reps %0d end %0b, got %0d %0d %0b",
                             beats_checked, want.duty, want.reps, want.run_end,
                             duty, reps, run_end));
         beats_checked++;
      endfunction

      function int pending();
         return due_words.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [COLOR_W-1:0]    req_first_color;
   logic [COLOR_W-1:0]    req_second_color;
   logic [COLOR_W-1:0]    req_third_color;
   logic                  req_last_pixel;
   logic                  rsp_valid;
   logic [DUTY_W-1:0]     rsp_duty_value;
   logic [REPEAT_W-1:0]   rsp_repeat_count;
   logic                  rsp_run_end;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   duty_word_checker_type checker_q = new();
   int quiet_cycles = 0;
   int settings_applied = 0;

   rgb_led_pulse_encoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_color  (req_first_color),
      .req_second_color (req_second_color),
      .req_third_color  (req_third_color),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_duty_value   (rsp_duty_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_run_end      (rsp_run_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sample every channel at the edge; the watchdog counts edges with no beat, pixel or register write.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready)
            checker_q.write_reg(csr_index, csr_data);
         if (start && !busy)
            checker_q.take_pixel(req_first_color, req_second_color, req_third_color,
                                 req_last_pixel);
         if (rsp_valid)
            checker_q.check_beat(rsp_duty_value, rsp_repeat_count, rsp_run_end);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d duty words outstanding",
                     WATCHDOG_LIMIT, checker_q.pending());
            $display("rgb_led_pulse_encoder_top_tb failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Leave start high on return so back-to-back pixels keep it asserted.
   task automatic send_pixel(input logic [COLOR_W-1:0] c0, c1, c2,
                             input logic last, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start            <= 1'b1;
      req_first_color  <= c0;
      req_second_color <= c1;
      req_third_color  <= c2;
      req_last_pixel   <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pixels();
      start <= 1'b0;
      do @(posedge clock); while (checker_q.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx,
                           input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Call only with the block drained.
   task automatic apply_setting(input logic [DUTY_W-1:0] period,
                                input logic [COLOR_W-1:0] bright,
                                input bit with_unused);
      logic [COLOR_W-1:0] junk;
      junk = COLOR_W'($urandom_range(255));
      if (with_unused) begin
         csr_beat(CSR_UNUSED_LO, CSR_DATA_W'($urandom));
         csr_beat(CSR_UNUSED_HI, CSR_DATA_W'($urandom));
      end
      csr_beat(CSR_TIMER_PERIOD, period);
      csr_beat(CSR_BRIGHTNESS, {junk, bright});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom_range(255));
      endcase
   endfunction

   initial begin
      int idle_pct [NUM_PHASES] = '{0, 83, 27, 0, 83, 27};
      logic [DUTY_W-1:0]  period;
      logic [COLOR_W-1:0] bright;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_first_color  <= '0;
      req_second_color <= '0;
      req_third_color  <= '0;
      req_last_pixel   <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_TIMER_PERIOD;
      csr_data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values: period 90, full brightness.
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 0);
      send_pixel(8'h80, 8'h01, 8'h80, 1'b1, 0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0, 0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b1, 0);
      send_pixel(8'h01, 8'h80, 8'h7F, 1'b1, 0);
      drain_pixels();

      // Largest period; writes to unused indexes must not land.
      apply_setting(16'hFFFF, 8'hFF, 1'b1);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 0);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b1, 0);
      drain_pixels();

      // Zero period and zero brightness: every duty collapses to 0.
      apply_setting(16'h0000, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 0);
      send_pixel(8'h12, 8'h34, 8'h56, 1'b1, 0);
      drain_pixels();

      apply_setting(16'h0001, 8'h01, 1'b0);
      send_pixel(8'hFF, 8'hFE, 8'h01, 1'b1, 0);
      drain_pixels();

      // Periods that do not divide by three truncate.
      apply_setting(16'h0002, 8'h80, 1'b1);
      send_pixel(8'hFF, 8'h80, 8'h7F, 1'b0, 0);
      send_pixel(8'hC3, 8'h3C, 8'h01, 1'b1, 0);
      drain_pixels();

      apply_setting(16'd100, 8'd200, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 0);
      send_pixel(8'hFE, 8'h02, 8'h81, 1'b1, 0);
      drain_pixels();

      apply_setting(16'hFFFE, 8'hFE, 1'b0);
      send_pixel(8'hFF, 8'h7F, 8'h80, 1'b0, 0);
      send_pixel(8'h01, 8'hFE, 8'hFF, 1'b1, 0);
      drain_pixels();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case ($urandom_range(5))
            0:       period = '0;
            1:       period = '1;
            2:       period = DUTY_W'($urandom_range(1, 5));
            3:       period = PERIOD_RESET;
            default: period = DUTY_W'($urandom_range(65535));
         endcase
         case ($urandom_range(4))
            0:       bright = '0;
            1:       bright = '1;
            2:       bright = COLOR_W'(1);
            default: bright = COLOR_W'($urandom_range(255));
         endcase
         apply_setting(period, bright, 1'($urandom_range(1)));
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            send_pixel(pick_color(), pick_color(), pick_color(),
                       $urandom_range(4) == 0, idle_pct[p]);
            // hold off now and then until the pipeline is empty
            if ($urandom_range(24) == 0)
               drain_pixels();
         end
         drain_pixels();
      end

      $display("covered %0d pixels in %0d frames over %0d register settings",
               checker_q.pixels_seen, checker_q.frames_seen, settings_applied + 1);
      $display("checked %0d duty beats, zero and full period and brightness included, %0d errors",
               checker_q.beats_checked, checker_q.failures);
      if (checker_q.failures == 0)
         $display("rgb_led_pulse_encoder_top_tb passed");
      else
         $display("rgb_led_pulse_encoder_top_tb failed");
      $finish;
   end

endmodule
